/* rtl/core/bap_pkg.sv */
// Shared types and constants for the block average pixelate core.
package bap_pkg;

	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int SLOT_W     = 2;
	localparam int ADDR_W     = SLOT_W + COL_W;
	localparam int STORE_DEPTH = 3072;
	localparam int BLK_PIX    = 9;
	localparam int IDX_W      = 4;
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 13;
	// Truncated divide by nine: (sum * 7282) >> 16 is exact for sums up to 2295.
	localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ALPHA  = 2'd2;

	typedef struct packed {
		logic [7:0] chan_zero;
		logic [7:0] chan_one;
		logic [7:0] chan_two;
		logic [7:0] alpha_in;
	} in_t;

	typedef struct packed {
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic [7:0]  avg_zero;
		logic [7:0]  avg_one;
		logic [7:0]  avg_two;
		logic [7:0]  alpha_out;
		logic        block_done;
	} out_t;

	// Row store write from the front.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} memw_t;

	// One finished block waiting to be read back.
	typedef struct packed {
		logic [ROW_W-1:0]  row0;
		logic [COL_W-1:0]  col0;
		logic [SLOT_W-1:0] slot0;
	} cmd_t;

	// Averaged block handed to the emitter.
	typedef struct packed {
		logic [ROW_W-1:0]      row0;
		logic [COL_W-1:0]      col0;
		logic [7:0]            avg0;
		logic [7:0]            avg1;
		logic [7:0]            avg2;
		logic [BLK_PIX-1:0][7:0] alpha;
	} blk_t;

endpackage

/* rtl/core/bap_cmd_fifo.sv */
// Two-entry queue of block commands between the front and the back.
module bap_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  bap_pkg::cmd_t wdata,
	input  logic          rd,
	output bap_pkg::cmd_t rdata,
	output logic          full,
	output logic          empty
);
	import bap_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

/* rtl/core/bap_front.sv */
// Front: configuration, pixel counters, row store writes and block detection.
module bap_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bap_pkg::in_t   pix,
	output logic           full,
	input  logic           wr_en,
	input  logic [1:0]     wr_index,
	input  logic [12:0]    wr_data,
	input  logic           fifo_full,
	input  logic           pending,
	output bap_pkg::memw_t memw,
	output logic           cmd_push,
	output bap_pkg::cmd_t  cmd
);
	import bap_pkg::*;

	logic [10:0]      width_q;
	logic [12:0]      height_q;
	logic             alpha_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [1:0]       rm_q;
	logic [1:0]       cm_q;

	logic [10:0] w_eff;
	logic [12:0] h_eff;
	logic        last_col;
	logic        last_row;
	logic        row_end;
	logic        col_end;
	logic        accept;
	logic [1:0]  rm_next;
	logic [1:0]  cm_next;

	// Saturate the frame size to the supported range.
	always_comb begin
		if (width_q < 11'd3) begin
			w_eff = 11'd3;
		end else if (width_q > 11'd1024) begin
			w_eff = 11'd1024;
		end else begin
			w_eff = width_q;
		end
		if (height_q < 13'd3) begin
			h_eff = 13'd3;
		end else if (height_q > 13'd4096) begin
			h_eff = 13'd4096;
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = ({1'b0, col_q} == (w_eff - 11'd1));
	assign last_row = ({1'b0, row_q} == (h_eff - 13'd1));
	assign row_end  = (rm_q == 2'd2) || last_row;
	assign col_end  = (cm_q == 2'd2) || last_col;
	assign rm_next  = (rm_q == 2'd2) ? 2'd0 : rm_q + 2'd1;
	assign cm_next  = (cm_q == 2'd2) ? 2'd0 : cm_q + 2'd1;

	// A new row waits until no block still has to read the store.
	assign full   = fifo_full || ((col_q == '0) && pending);
	assign accept = push && !full;

	// Row store write: slot is the row modulo three, then the column.
	always_comb begin
		memw.we   = accept;
		memw.addr = {rm_q, col_q};
		memw.data = {(alpha_q ? pix.alpha_in : 8'd0), pix.chan_two, pix.chan_one,
			pix.chan_zero};
	end

	// The block ending here starts two rows up and two columns left.
	always_comb begin
		cmd_push   = accept && row_end && col_end;
		cmd.row0   = row_q - ROW_W'(2);
		cmd.col0   = col_q - COL_W'(2);
		cmd.slot0  = rm_next;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
			alpha_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  width_q  <= wr_data[10:0];
				REG_HEIGHT: height_q <= wr_data;
				REG_ALPHA:  alpha_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Raster position; any valid register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rm_q  <= 2'd0;
			cm_q  <= 2'd0;
		end else if (wr_en && (wr_index <= REG_ALPHA)) begin
			row_q <= '0;
			col_q <= '0;
			rm_q  <= 2'd0;
			cm_q  <= 2'd0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				cm_q  <= 2'd0;
				if (last_row) begin
					row_q <= '0;
					rm_q  <= 2'd0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					rm_q  <= rm_next;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				cm_q  <= cm_next;
			end
		end
	end
endmodule

/* rtl/core/bap_back.sv */
// Back: row store, nine reads per block, channel sums and divide by nine.
module bap_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bap_pkg::memw_t memw,
	input  logic           fifo_empty,
	input  bap_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           pending,
	input  logic           emit_busy,
	output logic           blk_valid,
	output bap_pkg::blk_t  blk
);
	import bap_pkg::*;

	localparam logic [2:0] R_IDLE  = 3'd0;
	localparam logic [2:0] R_READ  = 3'd1;
	localparam logic [2:0] R_DRAIN = 3'd2;
	localparam logic [2:0] R_DIV   = 3'd3;
	localparam logic [2:0] R_HAND  = 3'd4;

	logic [31:0]      store_q [STORE_DEPTH];
	logic [31:0]      rdata_s1;
	logic             rdv_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [2:0]        st_q;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  k_q;
	logic [1:0]        a_q;
	logic [1:0]        b_q;
	logic [SUM_W-1:0]  sum0_q;
	logic [SUM_W-1:0]  sum1_q;
	logic [SUM_W-1:0]  sum2_q;
	logic [7:0]        avg0_q;
	logic [7:0]        avg1_q;
	logic [7:0]        avg2_q;
	logic [BLK_PIX-1:0][7:0] alpha_q;

	logic [2:0]        slot_sum;
	logic [ADDR_W-1:0] raddr;
	logic              rd_en;
	logic              start;
	logic              xfer;
	logic [SUM_W+RECIP_W-1:0] p0;
	logic [SUM_W+RECIP_W-1:0] p1;
	logic [SUM_W+RECIP_W-1:0] p2;

	// Read address of the current tap of the block.
	always_comb begin
		slot_sum = {1'b0, cmd_q.slot0} + {1'b0, a_q};
		if (slot_sum >= 3'd3) begin
			slot_sum = slot_sum - 3'd3;
		end
		raddr = {slot_sum[1:0], cmd_q.col0 + {{(COL_W-2){1'b0}}, b_q}};
	end

	assign rd_en   = (st_q == R_READ);
	assign pending = !fifo_empty || (st_q == R_READ);
	assign xfer    = (st_q == R_HAND) && !emit_busy;
	assign start   = !fifo_empty && ((st_q == R_IDLE) || xfer);
	assign cmd_pop = start;

	// Row store with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (memw.we) begin
			store_q[memw.addr] <= memw.data;
		end
		if (rd_en) begin
			rdata_s1 <= store_q[raddr];
		end
	end

	// Reciprocal multiply for the truncated mean.
	assign p0 = sum0_q * RECIP_NINE;
	assign p1 = sum1_q * RECIP_NINE;
	assign p2 = sum2_q * RECIP_NINE;

	// Block data path: sums, alpha capture and averages.
	always_ff @(posedge clk) begin
		idx_s1 <= k_q;
		if (start) begin
			cmd_q  <= cmd;
			sum0_q <= '0;
			sum1_q <= '0;
			sum2_q <= '0;
		end else if (rdv_s1) begin
			sum0_q <= sum0_q + {4'd0, rdata_s1[7:0]};
			sum1_q <= sum1_q + {4'd0, rdata_s1[15:8]};
			sum2_q <= sum2_q + {4'd0, rdata_s1[23:16]};
		end
		if (rdv_s1) begin
			alpha_q[idx_s1] <= rdata_s1[31:24];
		end
		if (st_q == R_DIV) begin
			avg0_q <= p0[23:16];
			avg1_q <= p1[23:16];
			avg2_q <= p2[23:16];
		end
	end

	// Sequencer over the nine taps of a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= R_IDLE;
			k_q    <= '0;
			a_q    <= 2'd0;
			b_q    <= 2'd0;
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= rd_en;
			if (start) begin
				st_q <= R_READ;
				k_q  <= '0;
				a_q  <= 2'd0;
				b_q  <= 2'd0;
			end else begin
				unique case (st_q)
					R_IDLE: ;
					R_READ: begin
						k_q <= k_q + IDX_W'(1);
						if (b_q == 2'd2) begin
							b_q <= 2'd0;
							a_q <= a_q + 2'd1;
						end else begin
							b_q <= b_q + 2'd1;
						end
						if (k_q == IDX_W'(BLK_PIX - 1)) begin
							st_q <= R_DRAIN;
						end
					end
					R_DRAIN: st_q <= R_DIV;
					R_DIV:   st_q <= R_HAND;
					R_HAND: begin
						if (xfer) begin
							st_q <= R_IDLE;
						end
					end
					default: st_q <= R_IDLE;
				endcase
			end
		end
	end

	assign blk_valid = xfer;
	always_comb begin
		blk.row0  = cmd_q.row0;
		blk.col0  = cmd_q.col0;
		blk.avg0  = avg0_q;
		blk.avg1  = avg1_q;
		blk.avg2  = avg2_q;
		blk.alpha = alpha_q;
	end

	// Read data only follows a read cycle.
	a_rdv_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> $past(st_q == R_READ))
		else $error("read data without a read");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == R_READ) |-> (k_q <= IDX_W'(BLK_PIX - 1)))
		else $error("tap counter out of range");

	a_drain_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == R_DRAIN) |=> (st_q == R_DIV))
		else $error("drain not followed by divide");

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ((st_q == R_IDLE) || (st_q == R_HAND)))
		else $error("block started while reading");
endmodule

/* rtl/core/bap_emit.sv */
// Emitter: walks one averaged block and drives the result register.
module bap_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          blk_valid,
	input  bap_pkg::blk_t blk,
	output logic          busy,
	input  logic          pop,
	output logic          empty,
	output bap_pkg::out_t res
);
	import bap_pkg::*;

	blk_t             blk_q;
	logic             busy_q;
	logic [IDX_W-1:0] eidx_q;
	logic [1:0]       ea_q;
	logic [1:0]       eb_q;
	logic             ovalid_q;
	out_t             res_q;
	logic             load;

	assign busy  = busy_q;
	assign empty = !ovalid_q;
	assign res   = res_q;
	assign load  = busy_q && (!ovalid_q || pop);

	// Held block and the result register payload.
	always_ff @(posedge clk) begin
		if (blk_valid) begin
			blk_q <= blk;
		end
		if (load) begin
			res_q.out_row    <= blk_q.row0 + {{(ROW_W-2){1'b0}}, ea_q};
			res_q.out_col    <= blk_q.col0 + {{(COL_W-2){1'b0}}, eb_q};
			res_q.avg_zero   <= blk_q.avg0;
			res_q.avg_one    <= blk_q.avg1;
			res_q.avg_two    <= blk_q.avg2;
			res_q.alpha_out  <= blk_q.alpha[eidx_q];
			res_q.block_done <= (eidx_q == IDX_W'(BLK_PIX - 1));
		end
	end

	// Position within the block and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			eidx_q   <= '0;
			ea_q     <= 2'd0;
			eb_q     <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			if (blk_valid) begin
				busy_q <= 1'b1;
				eidx_q <= '0;
				ea_q   <= 2'd0;
				eb_q   <= 2'd0;
			end else if (load) begin
				eidx_q <= eidx_q + IDX_W'(1);
				if (eb_q == 2'd2) begin
					eb_q <= 2'd0;
					ea_q <= ea_q + 2'd1;
				end else begin
					eb_q <= eb_q + 2'd1;
				end
				if (eidx_q == IDX_W'(BLK_PIX - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

/* rtl/core/block_average_pixelate.sv */
// Top level of the 3x3 block average pixelation core.
// Pixels enter in raster order, one per cycle while full is low. Each time a
// 3x3 block completes (shifted back at the right and bottom edges) its nine
// results come out in raster order with the block means, one per cycle while
// pop is high, from an output register. The block reader is paced by the nine
// reads through the single read port of the row store, so in the last row of
// each band of three rows input stalls while the two-entry command queue is
// full; at the start of each row input also waits until every queued block
// has finished reading the store. There is no clearing pass.
module block_average_pixelate (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  bap_pkg::in_t  pix,
	output logic          empty,
	input  logic          pop,
	output bap_pkg::out_t res,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [12:0]   wr_data
);
	import bap_pkg::*;

	memw_t memw;
	cmd_t  cmd_in;
	cmd_t  cmd_out;
	blk_t  blk;
	logic  cmd_push;
	logic  cmd_pop;
	logic  fifo_full;
	logic  fifo_empty;
	logic  pending;
	logic  emit_busy;
	logic  blk_valid;

	bap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pix       (pix),
		.full      (full),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.fifo_full (fifo_full),
		.pending   (pending),
		.memw      (memw),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	bap_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	bap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.memw       (memw),
		.fifo_empty (fifo_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.pending    (pending),
		.emit_busy  (emit_busy),
		.blk_valid  (blk_valid),
		.blk        (blk)
	);

	bap_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk       (blk),
		.busy      (emit_busy),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);
endmodule
